// ===== src/spm_pkg.sv =====
// Shared types and constants of the speed-binned peak monitor.
package spm_pkg;

  localparam int SPEED_BINS  = 128;
  localparam int BIN_W       = (SPEED_BINS > 1) ? $clog2(SPEED_BINS) : 1;
  localparam int QUEUE_DEPTH = 2;

  // Reciprocals for the rounding divisions by 125 and by 255.
  localparam logic [31:0] RECIP_125       = 32'd2199023256;
  localparam int          RECIP_125_SHIFT = 38;
  localparam logic [31:0] RECIP_255       = 32'd4210753;
  localparam int          RECIP_255_SHIFT = 30;

  localparam logic [23:0] ADDR_MOTOR_CURRENT = 24'h46000c;
  localparam logic [23:0] ADDR_MOTOR_VOLTAGE = 24'h46000d;
  localparam logic [23:0] ADDR_VOLT_MOD      = 24'h46000b;
  localparam logic [23:0] ADDR_SLIP_FREQ     = 24'h460001;
  localparam logic [23:0] ADDR_OUT_FREQ      = 24'h46000f;
  localparam logic [23:0] ADDR_TORQUE_DEMAND = 24'h46020b;
  localparam logic [23:0] ADDR_TORQUE        = 24'h46020c;
  localparam logic [23:0] ADDR_TORQUE_LIMIT  = 24'h46020e;
  localparam logic [23:0] ADDR_BATT_VOLTAGE  = 24'h460211;
  localparam logic [23:0] ADDR_CAP_VOLTAGE   = 24'h460212;

  typedef enum logic [3:0] {
    CH_NONE          = 4'd0,
    CH_MOTOR_CURRENT = 4'd1,
    CH_MOTOR_VOLTAGE = 4'd2,
    CH_VOLT_MOD      = 4'd3,
    CH_SLIP_FREQ     = 4'd4,
    CH_OUT_FREQ      = 4'd5,
    CH_TORQUE_DEMAND = 4'd6,
    CH_TORQUE        = 4'd7,
    CH_TORQUE_LIMIT  = 4'd8,
    CH_BATT_VOLTAGE  = 4'd9,
    CH_CAP_VOLTAGE   = 4'd10
  } chan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               clear;
    chan_t              ch;
    logic signed [15:0] raw;
    logic signed [15:0] opa;
    logic signed [15:0] opb;
    logic signed [15:0] trq;
    logic [7:0]         speed;
  } entry_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [31:0] scaled_value;
    logic signed [31:0] motor_power;
    logic               series_done;
    logic [7:0]         bin_used;
    logic               bin_in_range;
    logic               driving;
    logic signed [15:0] battery_power;
    logic               power_peak_raised;
    logic               torque_peak_raised;
  } result_t;

endpackage

// ===== src/spm_if.sv =====
// Input item and result channel interfaces.
interface spm_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               read_ok;
  logic [15:0]        object_index;
  logic [7:0]         object_subindex;
  logic signed [15:0] raw_value;
  logic [7:0]         speed_kph;
  logic signed [15:0] battery_current;

  modport source (output valid, func, read_ok, object_index, object_subindex, raw_value,
                  speed_kph, battery_current, input ready);
  modport sink (input valid, func, read_ok, object_index, object_subindex, raw_value,
                speed_kph, battery_current, output ready);
endinterface

interface spm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic signed [31:0] scaled_value;
  logic signed [31:0] motor_power;
  logic               series_done;
  logic [7:0]         bin_used;
  logic               bin_in_range;
  logic               driving;
  logic signed [15:0] battery_power;
  logic               power_peak_raised;
  logic               torque_peak_raised;

  modport source (output valid, channel, scaled_value, motor_power, series_done, bin_used,
                  bin_in_range, driving, battery_power, power_peak_raised,
                  torque_peak_raised, input ready);
  modport sink (input valid, channel, scaled_value, motor_power, series_done, bin_used,
                bin_in_range, driving, battery_power, power_peak_raised,
                torque_peak_raised, output ready);
endinterface

// ===== src/spm_front.sv =====
// Front end: accepts items, decodes the channel, keeps the latest raw values.
module spm_front (
  input  logic                clk,
  input  logic                rst,
  spm_in_if.sink              item,
  input  logic                full,
  output logic                push,
  output spm_pkg::entry_t     entry
);

  localparam int NUM_CHANNELS = 10;

  logic signed [15:0] channel_raw [NUM_CHANNELS];
  logic [23:0]        addr;
  spm_pkg::chan_t     dec_ch;

  assign addr = {item.object_index, item.object_subindex};

  always_comb begin
    dec_ch = spm_pkg::CH_NONE;
    if (!item.func && item.read_ok) begin
      case (addr)
        spm_pkg::ADDR_MOTOR_CURRENT: dec_ch = spm_pkg::CH_MOTOR_CURRENT;
        spm_pkg::ADDR_MOTOR_VOLTAGE: dec_ch = spm_pkg::CH_MOTOR_VOLTAGE;
        spm_pkg::ADDR_VOLT_MOD:      dec_ch = spm_pkg::CH_VOLT_MOD;
        spm_pkg::ADDR_SLIP_FREQ:     dec_ch = spm_pkg::CH_SLIP_FREQ;
        spm_pkg::ADDR_OUT_FREQ:      dec_ch = spm_pkg::CH_OUT_FREQ;
        spm_pkg::ADDR_TORQUE_DEMAND: dec_ch = spm_pkg::CH_TORQUE_DEMAND;
        spm_pkg::ADDR_TORQUE:        dec_ch = spm_pkg::CH_TORQUE;
        spm_pkg::ADDR_TORQUE_LIMIT:  dec_ch = spm_pkg::CH_TORQUE_LIMIT;
        spm_pkg::ADDR_BATT_VOLTAGE:  dec_ch = spm_pkg::CH_BATT_VOLTAGE;
        spm_pkg::ADDR_CAP_VOLTAGE:   dec_ch = spm_pkg::CH_CAP_VOLTAGE;
        default:                     dec_ch = spm_pkg::CH_NONE;
      endcase
    end
  end

  assign item.ready = !full;
  assign push       = item.valid && !full;

  always_comb begin
    entry.clear = item.func;
    entry.ch    = dec_ch;
    entry.raw   = item.raw_value;
    entry.opb   = item.battery_current;
    entry.trq   = channel_raw[spm_pkg::CH_TORQUE - 1];
    entry.speed = item.speed_kph;
    if (dec_ch == spm_pkg::CH_CAP_VOLTAGE) begin
      entry.opa = channel_raw[spm_pkg::CH_BATT_VOLTAGE - 1];
    end else begin
      entry.opa = channel_raw[spm_pkg::CH_MOTOR_CURRENT - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        channel_raw[k] <= '0;
      end
    end else if (push) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (4'(dec_ch) == 4'(k + 1)) begin
          channel_raw[k] <= item.raw_value;
        end
      end
    end
  end

endmodule

// ===== src/spm_queue.sv =====
// Short queue of decoded items between the front and back ends.
module spm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output spm_pkg::entry_t head
);

  localparam int QPTR_W = (spm_pkg::QUEUE_DEPTH > 1) ? $clog2(spm_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(spm_pkg::QUEUE_DEPTH + 1);

  spm_pkg::entry_t    slots [spm_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = (count == QCNT_W'(spm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(spm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(spm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/spm_back.sv =====
// Back end: scaling arithmetic, speed-bin peak maps and the result register.
module spm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  spm_pkg::entry_t head,
  output logic            pop,
  spm_out_if.source       result
);

  typedef struct packed {
    logic signed [15:0] drive_power;
    logic signed [15:0] recup_power;
    logic signed [15:0] drive_torque;
    logic signed [15:0] recup_torque;
  } map_row_t;

  function automatic logic [16:0] abs17(logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return e[16] ? 17'(-e) : e;
  endfunction

  function automatic logic signed [15:0] neg_sat16(logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  spm_pkg::state_t   state;
  spm_pkg::state_t   state_next;
  logic              mul_en;
  logic              load;

  spm_pkg::entry_t   ent;
  logic signed [15:0] op_a;
  logic signed [15:0] op_b;
  logic [33:0]       prod1;
  logic [30:0]       mag1;
  logic              neg1;

  logic [31:0]       y2;
  logic [31:0]       k2;
  logic [63:0]       prod2;
  logic [31:0]       q125;
  logic [31:0]       q255;
  logic [31:0]       mag3;

  map_row_t          map_mem [spm_pkg::SPEED_BINS];
  logic [spm_pkg::SPEED_BINS-1:0] row_valid;
  map_row_t          rd_row;
  logic              rd_valid;
  map_row_t          cur_row;
  map_row_t          new_row;
  logic [spm_pkg::BIN_W-1:0] rd_idx;
  logic [spm_pkg::BIN_W-1:0] wr_idx;
  logic              mem_we;
  logic              clear_go;

  logic [22:0]       w;
  logic signed [15:0] bpow;
  logic              drv;
  logic              in_range;
  logic              praised;
  logic              traised;
  logic signed [15:0] np;
  logic signed [15:0] nt;

  spm_pkg::result_t  res;
  spm_pkg::result_t  res_next;
  logic              res_valid;

  always_comb begin
    state_next = state;
    case (state)
      spm_pkg::ST_IDLE: if (head_valid) state_next = spm_pkg::ST_MUL;
      spm_pkg::ST_MUL:  state_next = spm_pkg::ST_FIN;
      spm_pkg::ST_FIN:  if (!res_valid || result.ready) state_next = spm_pkg::ST_IDLE;
      default:          state_next = spm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    mul_en = 1'b0;
    load   = 1'b0;
    case (state)
      spm_pkg::ST_IDLE: pop    = head_valid;
      spm_pkg::ST_MUL:  mul_en = 1'b1;
      spm_pkg::ST_FIN:  load   = !res_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stage one: magnitude product and sign.
  always_comb begin
    op_a = ent.raw;
    op_b = ent.opa;
    case (ent.ch)
      spm_pkg::CH_CAP_VOLTAGE: begin
        op_a = ent.opa;
        op_b = ent.opb;
      end
      spm_pkg::CH_VOLT_MOD: op_b = 16'sd100;
      default: ;
    endcase
  end

  assign prod1 = 34'(abs17(op_a)) * 34'(abs17(op_b));

  always_ff @(posedge clk) begin
    if (pop) begin
      ent      <= head;
      rd_row   <= map_mem[rd_idx];
      rd_valid <= row_valid[rd_idx];
    end
    if (mul_en) begin
      mag1 <= prod1[30:0];
      neg1 <= op_a[15] ^ op_b[15];
    end
  end

  // Stage two: rounding divisions by reciprocal.
  always_comb begin
    if (ent.ch == spm_pkg::CH_MOTOR_VOLTAGE) begin
      y2 = {mag1, 1'b0} + 32'd62;
      k2 = spm_pkg::RECIP_125;
    end else begin
      y2 = {1'b0, mag1} + 32'd127;
      k2 = spm_pkg::RECIP_255;
    end
  end

  assign prod2 = 64'(y2) * 64'(k2);
  assign q125  = 32'(prod2 >> spm_pkg::RECIP_125_SHIFT);
  assign q255  = 32'(prod2 >> spm_pkg::RECIP_255_SHIFT);
  assign mag3  = {1'b0, mag1} + q255;

  // Series close: battery power and peak update.
  assign w        = mag1[30:8];
  assign drv      = !neg1 && (mag1 != '0);
  assign in_range = ({1'b0, ent.speed} < 9'(spm_pkg::SPEED_BINS));
  assign cur_row  = rd_valid ? rd_row : '0;
  assign np       = neg_sat16(bpow);
  assign nt       = neg_sat16(ent.trq);

  always_comb begin
    if (neg1) begin
      bpow = (w > 23'd32768) ? 16'sh8000 : -$signed(w[15:0]);
    end else begin
      bpow = (w > 23'd32767) ? 16'sh7fff : $signed(w[15:0]);
    end
  end

  always_comb begin
    new_row = cur_row;
    praised = 1'b0;
    traised = 1'b0;
    if (drv) begin
      if (cur_row.drive_power < bpow) begin
        new_row.drive_power = bpow;
        praised = 1'b1;
      end
      if (cur_row.drive_torque < ent.trq) begin
        new_row.drive_torque = ent.trq;
        traised = 1'b1;
      end
    end else begin
      if (cur_row.recup_power < np) begin
        new_row.recup_power = np;
        praised = 1'b1;
      end
      if (cur_row.recup_torque < nt) begin
        new_row.recup_torque = nt;
        traised = 1'b1;
      end
    end
  end

  assign rd_idx   = head.speed[spm_pkg::BIN_W-1:0];
  assign wr_idx   = ent.speed[spm_pkg::BIN_W-1:0];
  assign mem_we   = load && (ent.ch == spm_pkg::CH_CAP_VOLTAGE) && in_range;
  assign clear_go = load && ent.clear;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_idx] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (clear_go) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[wr_idx] <= 1'b1;
    end
  end

  // Result assembly.
  always_comb begin
    res_next         = '0;
    res_next.channel = 4'(ent.ch);
    case (ent.ch)
      spm_pkg::CH_NONE:          res_next.scaled_value = '0;
      spm_pkg::CH_MOTOR_CURRENT: res_next.scaled_value = {{8{ent.raw[15]}}, ent.raw, 8'h00};
      spm_pkg::CH_VOLT_MOD:      res_next.scaled_value = neg1 ? -$signed(mag3) : $signed(mag3);
      spm_pkg::CH_SLIP_FREQ:     res_next.scaled_value = {{16{ent.raw[15]}}, ent.raw};
      default:                   res_next.scaled_value = {{12{ent.raw[15]}}, ent.raw, 4'h0};
    endcase
    if (ent.ch == spm_pkg::CH_MOTOR_VOLTAGE) begin
      res_next.motor_power = neg1 ? -$signed(q125) : $signed(q125);
    end
    if (ent.ch == spm_pkg::CH_CAP_VOLTAGE) begin
      res_next.series_done        = 1'b1;
      res_next.bin_used           = ent.speed;
      res_next.bin_in_range       = in_range;
      res_next.driving            = drv;
      res_next.battery_power      = bpow;
      res_next.power_peak_raised  = praised && in_range;
      res_next.torque_peak_raised = traised && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid              = res_valid;
  assign result.channel            = res.channel;
  assign result.scaled_value       = res.scaled_value;
  assign result.motor_power        = res.motor_power;
  assign result.series_done        = res.series_done;
  assign result.bin_used           = res.bin_used;
  assign result.bin_in_range       = res.bin_in_range;
  assign result.driving            = res.driving;
  assign result.battery_power      = res.battery_power;
  assign result.power_peak_raised  = res.power_peak_raised;
  assign result.torque_peak_raised = res.torque_peak_raised;

  a_fin_after_mul: assert property (@(posedge clk) disable iff (rst)
    state == spm_pkg::ST_FIN |-> $past(state) == spm_pkg::ST_MUL
                                 || $past(state) == spm_pkg::ST_FIN)
    else $error("back end reached finish without a multiply step");

  a_series_tag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.series_done == (res.channel == spm_pkg::CH_CAP_VOLTAGE))
    else $error("series_done does not match the capacitor voltage channel");

  a_raise_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.power_peak_raised || res.torque_peak_raised) |-> res.bin_in_range)
    else $error("peak raised outside the map");

  a_write_in_fin: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == spm_pkg::ST_FIN && !clear_go)
    else $error("peak map written outside the finish step");

endmodule

// ===== src/speed_binned_peak_monitor.sv =====
// Top level of the speed-binned peak monitor.
//
//   port    | dir | handshake    | payload
//   --------+-----+--------------+-----------------------------------------------
//   item    | in  | valid/ready  | func, read_ok, object_index/subindex, raw_value,
//           |     |              | speed_kph, battery_current
//   result  | out | valid/ready  | channel, scaled_value, motor_power, series fields
//
// One result per transfer. Each item passes in turn through a pop with map row
// read, one 17x17 multiply, one 32x32 reciprocal multiply with map write and result
// load; the back end pops no new item until the result register has taken the last.
// A two-entry queue lets the front take transfers while the back end or the
// result register stalls. Reset clears the latest raw values and marks all map
// rows empty; a clear item does the same for the maps.
module speed_binned_peak_monitor (
  input  logic       clk,
  input  logic       rst,
  spm_in_if.sink     item,
  spm_out_if.source  result
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  spm_pkg::entry_t push_entry;
  spm_pkg::entry_t head;

  spm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  spm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  spm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule
